/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file of the span solver.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSSAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NSSAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/nssas_pkg.sv */
// Shared widths, codes and descriptor types of the nine-slice span solver.
// No dependencies; used by the interfaces and all solver modules.
package nssas_pkg;

  localparam int TEX_W   = 13;
  localparam int INSET_W = 14;
  localparam int CROP_W  = 13;
  localparam int SIDE_W  = 2;
  localparam int POS_W   = 12;
  localparam int LEN_W   = 13;

  // Internal unsigned width of sizes, insets and lengths.
  localparam int VW = 14;
  // Signed width of tiling positions and phase sums.
  localparam int XW = VW + 2;

  // Depth of the queue between front and back.
  localparam int QD = 2;

  localparam logic [SIDE_W-1:0] SIDE_NEAR = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_FAR  = 2'd2;

  // One classified request, as handed from the front to the back.
  typedef struct packed {
    logic                     inval;
    logic                     tiles;
    logic [VW-1:0]            a;
    logic [VW-1:0]            da;
    logic [VW-1:0]            db;
    logic [VW-1:0]            dmid;
    logic [VW-1:0]            smid;
    logic [VW-1:0]            far_src;
    logic [VW-1:0]            far_dst;
    logic [SIDE_W-1:0]        side;
    logic signed [CROP_W-1:0] crop;
  } desc_t;

  typedef struct packed {
    logic          start;
    logic [VW-1:0] dividend;
    logic [VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [VW-1:0] rem;
  } div_rsp_t;

endpackage

/* hw/rtl/nssas_if.sv */
// Request and span channel interfaces of the nine-slice span solver.
// Depends on nssas_pkg for field widths.
interface nssas_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [nssas_pkg::TEX_W-1:0]              tex_size;
  logic signed [nssas_pkg::INSET_W-1:0]     inset_near;
  logic signed [nssas_pkg::INSET_W-1:0]     inset_far;
  logic [nssas_pkg::TEX_W-1:0]              dest_size;
  logic [nssas_pkg::SIDE_W-1:0]             anchor_side;
  logic signed [nssas_pkg::CROP_W-1:0]      crop_offset;

  modport source (output valid, tex_size, inset_near, inset_far, dest_size,
                  anchor_side, crop_offset, input ready);
  modport sink (input valid, tex_size, inset_near, inset_far, dest_size,
                anchor_side, crop_offset, output ready);
endinterface

interface nssas_out_if;
  logic                        valid;
  logic                        ready;
  logic                        valid_res;
  logic [nssas_pkg::POS_W-1:0] src_start;
  logic [nssas_pkg::POS_W-1:0] dst_start;
  logic [nssas_pkg::LEN_W-1:0] span_len;
  logic                        last_span;
  logic                        truncated;

  modport source (output valid, valid_res, src_start, dst_start, span_len,
                  last_span, truncated, input ready);
  modport sink (input valid, valid_res, src_start, dst_start, span_len,
                last_span, truncated, output ready);
endinterface

/* hw/rtl/nssas_front.sv */
// Front of the span solver: takes requests, saturates sizes, fixes insets.
// Depends on nssas_pkg and nssas_in_if; feeds descriptors to nssas_fifo.
module nssas_front #(
  parameter int MAX_SIZE = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  nssas_in_if.sink         in_ch,
  output logic             push,
  output nssas_pkg::desc_t wr_data,
  input  logic             full
);

  // Sizes can never exceed what the 13-bit fields carry.
  localparam int SAT = (MAX_SIZE > 8191) ? 8191 : MAX_SIZE;

  logic                                   stg_vld_r;
  logic [nssas_pkg::TEX_W-1:0]            tex_r;
  logic [nssas_pkg::TEX_W-1:0]            dst_r;
  logic signed [nssas_pkg::INSET_W-1:0]   nr_r;
  logic signed [nssas_pkg::INSET_W-1:0]   fr_r;
  logic [nssas_pkg::SIDE_W-1:0]           side_r;
  logic signed [nssas_pkg::CROP_W-1:0]    crop_r;

  logic [nssas_pkg::VW-1:0] n, d, a, b, half, da, rem_d, db;
  logic [nssas_pkg::VW:0]   sum;
  logic                     bad;

  assign in_ch.ready = !stg_vld_r || !full;
  assign push        = stg_vld_r && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      tex_r  <= in_ch.tex_size;
      dst_r  <= in_ch.dest_size;
      nr_r   <= in_ch.inset_near;
      fr_r   <= in_ch.inset_far;
      side_r <= in_ch.anchor_side;
      crop_r <= in_ch.crop_offset;
    end
  end

  always_comb begin
    n = (int'(tex_r) > SAT) ? nssas_pkg::VW'(SAT) : nssas_pkg::VW'(tex_r);
    d = (int'(dst_r) > SAT) ? nssas_pkg::VW'(SAT) : nssas_pkg::VW'(dst_r);
    // Insets that are negative or leave no interior fall back to plain wrap.
    sum   = {1'b0, nr_r[nssas_pkg::VW-1:0]} + {1'b0, fr_r[nssas_pkg::VW-1:0]};
    bad   = nr_r[nssas_pkg::INSET_W-1] || fr_r[nssas_pkg::INSET_W-1] || (sum >= {1'b0, n});
    a     = bad ? '0 : nr_r[nssas_pkg::VW-1:0];
    b     = bad ? '0 : fr_r[nssas_pkg::VW-1:0];
    half  = d >> 1;
    da    = (a < half) ? a : half;
    rem_d = d - da;
    db    = (b < rem_d) ? b : rem_d;

    wr_data.inval   = (tex_r == '0) || (dst_r == '0);
    wr_data.a       = a;
    wr_data.da      = da;
    wr_data.db      = db;
    wr_data.dmid    = rem_d - db;
    wr_data.tiles   = (rem_d != db);
    wr_data.smid    = n - a - b;
    wr_data.far_src = n - db;
    wr_data.far_dst = d - db;
    wr_data.side    = side_r;
    wr_data.crop    = crop_r;
  end

endmodule

/* hw/rtl/nssas_fifo.sv */
// Short descriptor queue that decouples the front from the back.
// Depends on nssas_pkg for the descriptor type and depth.
module nssas_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  nssas_pkg::desc_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_vld,
  output nssas_pkg::desc_t rd_data
);

  localparam int QAW = $clog2(nssas_pkg::QD);

  nssas_pkg::desc_t mem_r [nssas_pkg::QD];
  logic [QAW-1:0]   wp_r;
  logic [QAW-1:0]   rp_r;
  logic [QAW:0]     cnt_r;

  assign full    = (cnt_r == (QAW+1)'(nssas_pkg::QD));
  assign rd_vld  = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/nssas_div.sv */
// Restoring remainder unit, one quotient bit per cycle.
// Depends on nssas_pkg for operand width and request/response types.
module nssas_div (
  input  logic                clk,
  input  logic                rst_n,
  input  nssas_pkg::div_req_t req,
  output nssas_pkg::div_rsp_t rsp
);

  localparam int W   = nssas_pkg::VW;
  localparam int DCW = $clog2(W);

  logic           busy_r, done_r;
  logic [DCW-1:0] cnt_r;
  logic [W-1:0]   rem_r, dvd_r, dvs_r;
  logic [W:0]     t, diff;
  logic           ge;

  assign t    = {rem_r, dvd_r[W-1]};
  assign diff = t - {1'b0, dvs_r};
  assign ge   = (t >= {1'b0, dvs_r});

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DCW'(1);
      if (cnt_r == DCW'(W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : t[W-1:0];
      dvd_r <= dvd_r << 1;
    end
  end

endmodule

/* hw/rtl/nssas_back.sv */
// Back of the span solver: phase computation and span emission sequencer.
// Depends on nssas_pkg, nssas_out_if and the nssas_div remainder unit.
module nssas_back #(
  parameter int MAX_SPANS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_vld,
  input  nssas_pkg::desc_t q_data,
  output logic             pop,
  nssas_out_if.source      out_ch
);

  localparam int VW = nssas_pkg::VW;
  localparam int XW = nssas_pkg::XW;
  localparam int CW = $clog2(MAX_SPANS + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INVAL  = 8'b0000_0010,
    S_CORN_N = 8'b0000_0100,
    S_CORN_F = 8'b0000_1000,
    S_DIV_R  = 8'b0001_0000,
    S_PREP   = 8'b0010_0000,
    S_DIV_P  = 8'b0100_0000,
    S_TILE   = 8'b1000_0000
  } state_t;

  function automatic logic signed [XW-1:0] to_x(input logic [VW-1:0] v);
    return signed'({{(XW-VW){1'b0}}, v});
  endfunction

  state_t              st_r, st_nxt;
  nssas_pkg::desc_t    dsc_r, dsc_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [VW-1:0]       sf_r, sf_nxt;
  logic                p_neg_r, p_neg_nxt;
  logic signed [XW-1:0] x_r, x_nxt;

  logic                        ov_r, o_vres_r, o_last_r, o_trunc_r;
  logic [nssas_pkg::POS_W-1:0] o_src_r, o_dst_r;
  logic [nssas_pkg::LEN_W-1:0] o_len_r;

  logic                 emit, e_vres, e_last, e_trunc;
  logic [VW-1:0]        e_src, e_dst, e_len;
  logic                 slot_free;

  nssas_pkg::div_req_t  dreq;
  nssas_pkg::div_rsp_t  drsp;

  logic [VW-1:0]        ph0;
  logic signed [XW-1:0] p, p_abs, m_x, smid_x, dmid_x;
  logic signed [XW-1:0] t_xe, t_vs, t_ve, t_len, t_src, t_dst;
  logic                 t_more, t_cap, t_last, cn_last;

  nssas_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (dreq),
    .rsp (drsp)
  );

  assign slot_free = !ov_r || out_ch.ready;

  // Phase of the interior: side-selected share of the shortfall plus crop.
  always_comb begin
    case (dsc_r.side)
      nssas_pkg::SIDE_NEAR: ph0 = '0;
      nssas_pkg::SIDE_FAR:  ph0 = sf_r;
      default:              ph0 = sf_r >> 1;
    endcase
  end

  assign p      = to_x(ph0) + XW'(dsc_r.crop);
  assign p_abs  = p[XW-1] ? -p : p;
  assign m_x    = to_x(drsp.rem);
  assign smid_x = to_x(dsc_r.smid);
  assign dmid_x = to_x(dsc_r.dmid);

  // One interior tile clipped to the interior window.
  assign t_xe   = x_r + smid_x;
  assign t_vs   = x_r[XW-1] ? '0 : x_r;
  assign t_more = (t_xe < dmid_x);
  assign t_ve   = t_more ? t_xe : dmid_x;
  assign t_len  = t_ve - t_vs;
  assign t_src  = to_x(dsc_r.a) + t_vs - x_r;
  assign t_dst  = to_x(dsc_r.da) + t_vs;
  assign t_cap  = (cnt_r == CW'(MAX_SPANS - 1));
  assign t_last = !t_more || t_cap;

  assign cn_last = (dsc_r.db == '0) && !dsc_r.tiles;

  always_comb begin
    st_nxt    = st_r;
    dsc_nxt   = dsc_r;
    cnt_nxt   = cnt_r;
    sf_nxt    = sf_r;
    p_neg_nxt = p_neg_r;
    x_nxt     = x_r;
    pop       = 1'b0;
    emit      = 1'b0;
    e_vres    = 1'b1;
    e_src     = '0;
    e_dst     = '0;
    e_len     = '0;
    e_last    = 1'b0;
    e_trunc   = 1'b0;
    dreq      = '0;
    case (st_r)
      S_IDLE: begin
        if (q_vld) begin
          pop     = 1'b1;
          dsc_nxt = q_data;
          cnt_nxt = '0;
          st_nxt  = q_data.inval ? S_INVAL : S_CORN_N;
        end
      end
      S_INVAL: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_vres = 1'b0;
          e_last = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_CORN_N: begin
        if (dsc_r.da == '0) begin
          st_nxt = S_CORN_F;
        end else if (slot_free) begin
          emit   = 1'b1;
          e_len  = dsc_r.da;
          e_last = cn_last;
          st_nxt = cn_last ? S_IDLE : S_CORN_F;
        end
      end
      S_CORN_F: begin
        if ((dsc_r.db == '0) || slot_free) begin
          emit   = (dsc_r.db != '0);
          e_src  = dsc_r.far_src;
          e_dst  = dsc_r.far_dst;
          e_len  = dsc_r.db;
          e_last = !dsc_r.tiles;
          if (dsc_r.tiles) begin
            dreq.start    = 1'b1;
            dreq.dividend = dsc_r.dmid;
            dreq.divisor  = dsc_r.smid;
            st_nxt        = S_DIV_R;
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_DIV_R: begin
        if (drsp.done) begin
          sf_nxt = (drsp.rem == '0) ? '0 : dsc_r.smid - drsp.rem;
          st_nxt = S_PREP;
        end
      end
      S_PREP: begin
        p_neg_nxt     = p[XW-1];
        dreq.start    = 1'b1;
        dreq.dividend = p_abs[VW-1:0];
        dreq.divisor  = dsc_r.smid;
        st_nxt        = S_DIV_P;
      end
      S_DIV_P: begin
        if (drsp.done) begin
          if (!p_neg_r) begin
            x_nxt = -m_x;
          end else if (drsp.rem == '0) begin
            x_nxt = '0;
          end else begin
            x_nxt = m_x - smid_x;
          end
          st_nxt = S_TILE;
        end
      end
      S_TILE: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_src   = t_src[VW-1:0];
          e_dst   = t_dst[VW-1:0];
          e_len   = t_len[VW-1:0];
          e_last  = t_last;
          e_trunc = t_more && t_cap;
          x_nxt   = t_xe;
          st_nxt  = t_last ? S_IDLE : S_TILE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    if (emit) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dsc_r   <= dsc_nxt;
    cnt_r   <= cnt_nxt;
    sf_r    <= sf_nxt;
    p_neg_r <= p_neg_nxt;
    x_r     <= x_nxt;
    if (emit) begin
      o_vres_r  <= e_vres;
      o_src_r   <= e_src[nssas_pkg::POS_W-1:0];
      o_dst_r   <= e_dst[nssas_pkg::POS_W-1:0];
      o_len_r   <= e_len[nssas_pkg::LEN_W-1:0];
      o_last_r  <= e_last;
      o_trunc_r <= e_trunc;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.valid_res = o_vres_r;
  assign out_ch.src_start = o_src_r;
  assign out_ch.dst_start = o_dst_r;
  assign out_ch.span_len  = o_len_r;
  assign out_ch.last_span = o_last_r;
  assign out_ch.truncated = o_trunc_r;

endmodule

/* hw/rtl/nine_slice_axis_span_solver.sv */
// Nine-slice axis span solver. Each request describes one axis of a nine-slice
// blit and produces the near-corner span, the far-corner span and then the
// spans that tile the interior, each as a source start, a destination start and
// a length; a request with a zero texture or destination size produces one
// result with valid_res low. Each request is dequeued and then steps through
// the near-corner and far-corner states, even when a corner is empty, except
// that the far-corner state is skipped when the near-corner span is the last.
// A request with a zero size instead goes from the dequeue straight to its
// single result. When there is an interior, two remainder computations run
// next in the shared one-bit-per-cycle divider. Each takes 14 steps and then
// signals done, with the S_PREP state between them to form the phase. The
// interior spans follow, one per cycle while the output register is free.
// Each result is registered in the output register and presented in the
// cycle after it is formed. The span counter caps a request at MAX_SPANS
// results, and the last result then carries truncated. A two-entry descriptor
// queue lets the front take up to three new requests while the back is still
// busy. When the receiver stalls, the output register holds the waiting result
// and the back waits with it, while the front keeps filling the queue.
// Depends on nssas_pkg, nssas_if, nssas_front, nssas_fifo, nssas_div and
// nssas_back.
module nine_slice_axis_span_solver #(
  parameter int MAX_SIZE  = 4096,
  parameter int MAX_SPANS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  nssas_in_if.sink     in_ch,
  nssas_out_if.source  out_ch
);

  // Descriptor handoff between the classifier and the span sequencer.
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_vld;
  nssas_pkg::desc_t q_wr_data;
  nssas_pkg::desc_t q_rd_data;

  // The front saturates sizes, drops insets that leave no interior and fits
  // the insets to the destination, producing one descriptor per request.
  nssas_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full)
  );

  nssas_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_vld  (q_vld),
    .rd_data (q_rd_data)
  );

  // The back works out the tiling phase and walks the interior one tile per
  // cycle, stalling only on the output register.
  nssas_back #(
    .MAX_SPANS (MAX_SPANS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_data (q_rd_data),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

/* hw/rtl/nssas_chk.sv */
// Port-level checker for the nine-slice span solver, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module nssas_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valid_res,
  input logic [11:0] src_start,
  input logic [11:0] dst_start,
  input logic [12:0] span_len,
  input logic        last_span,
  input logic        truncated
);

  `NSSAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(src_start) && $stable(dst_start) && $stable(span_len) && $stable(last_span) && $stable(truncated) && $stable(valid_res), "stalled result changed")
  `NSSAS_ASSERT_NOW(a_inval_form, clk, rst_n, out_valid && !valid_res, last_span && !truncated && (span_len == 13'd0), "invalid result is not a lone empty item")
  `NSSAS_ASSERT_NOW(a_trunc_last, clk, rst_n, out_valid && truncated, last_span && valid_res, "truncated set on a result that is not last")
  `NSSAS_ASSERT_NOW(a_span_len, clk, rst_n, out_valid && valid_res, span_len != 13'd0, "real span has zero length")

endmodule

bind nine_slice_axis_span_solver nssas_chk u_nssas_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .valid_res (out_ch.valid_res),
  .src_start (out_ch.src_start),
  .dst_start (out_ch.dst_start),
  .span_len  (out_ch.span_len),
  .last_span (out_ch.last_span),
  .truncated (out_ch.truncated)
);

/* sim/tb.sv */
// Self-checking testbench for the nine-slice axis span solver.
// Drives requests over nssas_in_if, checks each span against a local solver or table.
// Depends on nssas_pkg, nssas_if and the nine_slice_axis_span_solver RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nssas_pkg::*;

  localparam int MAX_SIZE  = 4096;
  localparam int MAX_SPANS = 64;

  // The package names only the near and far anchor codes.
  localparam logic [SIDE_W-1:0] SIDE_CENTER = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_SPARE  = 2'd3;

  localparam int RANDOM_ITEMS = 430;
  localparam int CALM_ITEMS   = 60;    // final stretch with no idling on either side
  localparam int DRAIN_CYCLES = 120;   // divider setup plus a full run of spans

  // One request as it travels on the input channel.
  typedef struct {
    logic [TEX_W-1:0]          tex_size;
    logic signed [INSET_W-1:0] inset_near;
    logic signed [INSET_W-1:0] inset_far;
    logic [TEX_W-1:0]          dest_size;
    logic [SIDE_W-1:0]         anchor_side;
    logic signed [CROP_W-1:0]  crop_offset;
  } axis_req_t;

  // One result as it travels on the output channel.
  typedef struct {
    logic             valid_res;
    logic [POS_W-1:0] src_start;
    logic [POS_W-1:0] dst_start;
    logic [LEN_W-1:0] span_len;
    logic             last_span;
    logic             truncated;
  } span_t;

  // A directed row: when known is set, the single span typed in is expected instead of
  // whatever the local solver would compute.
  typedef struct {
    axis_req_t req;
    bit        known;
    span_t     known_span;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  nssas_in_if  in_ch ();
  nssas_out_if out_ch ();

  nine_slice_axis_span_solver #(
    .MAX_SIZE  (MAX_SIZE),
    .MAX_SPANS (MAX_SPANS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Spans still owed by the block, oldest first.
  span_t    spans_due[$];
  dir_row_t dir_rows[$];
  int       fail_count = 0;

  // Idling controls, set by the stimulus process and read by both channel drivers.
  int in_gap_pct   = 0;
  int stall_pct    = 0;
  bit calm_tail    = 1'b0;

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Appends one span unless the per-request limit is already reached, in which case
  // the request is marked as having dropped spans.
  function automatic void place_span(ref span_t row[$], ref bit dropped,
                                     input int src, input int dst, input int len);
    span_t sp;
    if (row.size() >= MAX_SPANS) begin
      dropped = 1'b1;
      return;
    end
    sp.valid_res = 1'b1;
    sp.src_start = POS_W'(src);
    sp.dst_start = POS_W'(dst);
    sp.span_len  = LEN_W'(len);
    sp.last_span = 1'b0;
    sp.truncated = 1'b0;
    row.push_back(sp);
  endfunction

  // Works out every span that one request produces and queues them as expected.
  function automatic void solve_axis(input axis_req_t r);
    int    tex, near_in, far_in, dest;
    int    near_d, far_d, mid_d, mid_s, shortfall, phase, x, vis_lo, vis_hi;
    bit    dropped;
    span_t row[$];
    span_t sp;
    tex     = int'(r.tex_size);
    dest    = int'(r.dest_size);
    near_in = int'(r.inset_near);
    far_in  = int'(r.inset_far);
    dropped = 1'b0;
    if (tex > MAX_SIZE) tex = MAX_SIZE;
    if (dest > MAX_SIZE) dest = MAX_SIZE;

    // A zero size leaves nothing to draw: one empty result closes the request.
    if (tex == 0 || dest == 0) begin
      sp = '{valid_res: 1'b0, src_start: '0, dst_start: '0, span_len: '0,
             last_span: 1'b1, truncated: 1'b0};
      spans_due.push_back(sp);
      return;
    end

    // Insets that leave no interior, or a negative one, fall back to plain wrap.
    if (near_in < 0 || far_in < 0 || near_in + far_in >= tex) begin
      near_in = 0;
      far_in  = 0;
    end

    // Corners shrink to fit a narrow destination, near side first.
    near_d = (near_in < dest / 2) ? near_in : dest / 2;
    far_d  = (far_in < dest - near_d) ? far_in : dest - near_d;

    if (near_d > 0) place_span(row, dropped, 0, 0, near_d);
    if (far_d > 0) place_span(row, dropped, tex - far_d, dest - far_d, far_d);

    mid_d = dest - near_d - far_d;
    mid_s = tex - near_in - far_in;
    if (mid_d > 0 && mid_s > 0) begin
      shortfall = (mid_s - (mid_d % mid_s)) % mid_s;
      if (r.anchor_side == SIDE_NEAR) phase = 0;
      else if (r.anchor_side == SIDE_FAR) phase = shortfall;
      else phase = shortfall / 2;
      phase = ((phase + int'(r.crop_offset)) % mid_s + mid_s) % mid_s;
      for (x = -phase; x < mid_d && !dropped; x += mid_s) begin
        vis_lo = (x > 0) ? x : 0;
        vis_hi = (x + mid_s < mid_d) ? x + mid_s : mid_d;
        if (vis_hi - vis_lo <= 0) continue;
        place_span(row, dropped, near_in + (vis_lo - x), near_d + vis_lo, vis_hi - vis_lo);
      end
    end

    if (row.size() > 0) begin
      row[row.size()-1].last_span = 1'b1;
      row[row.size()-1].truncated = dropped;
    end
    foreach (row[i]) spans_due.push_back(row[i]);
  endfunction

  function automatic axis_req_t mk_req(input int tex, input int near_in, input int far_in,
                                       input int dest, input logic [SIDE_W-1:0] side,
                                       input int crop);
    axis_req_t r;
    r.tex_size    = TEX_W'(tex);
    r.inset_near  = INSET_W'(near_in);
    r.inset_far   = INSET_W'(far_in);
    r.dest_size   = TEX_W'(dest);
    r.anchor_side = side;
    r.crop_offset = CROP_W'(crop);
    return r;
  endfunction

  function automatic span_t mk_span(input logic ok, input int src, input int dst,
                                    input int len);
    span_t sp;
    sp.valid_res = ok;
    sp.src_start = POS_W'(src);
    sp.dst_start = POS_W'(dst);
    sp.span_len  = LEN_W'(len);
    sp.last_span = 1'b1;
    sp.truncated = 1'b0;
    return sp;
  endfunction

  function automatic void add_row(input axis_req_t r);
    dir_rows.push_back('{req: r, known: 1'b0, known_span: mk_span(1'b0, 0, 0, 0)});
  endfunction

  function automatic void add_known_row(input axis_req_t r, input span_t sp);
    dir_rows.push_back('{req: r, known: 1'b1, known_span: sp});
  endfunction

  // Sizes lean small so that many requests finish before the span limit, with a
  // share at full range and above the saturation point.
  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(1, 16);
    else if (roll < 70) return $urandom_range(1, 256);
    else if (roll < 94) return $urandom_range(1, MAX_SIZE);
    else return $urandom_range(MAX_SIZE + 1, 8191);
  endfunction

  function automatic axis_req_t pick_req();
    axis_req_t r;
    int        kind, tex, dest, tex_sat, near_in, far_in, crop;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      // Raw noise over every bit of every field.
      r.tex_size    = TEX_W'($urandom);
      r.inset_near  = INSET_W'($urandom);
      r.inset_far   = INSET_W'($urandom);
      r.dest_size   = TEX_W'($urandom);
      r.anchor_side = SIDE_W'($urandom);
      r.crop_offset = CROP_W'($urandom);
      return r;
    end
    tex  = pick_size();
    dest = pick_size();
    if (kind < 10) begin
      if ($urandom_range(0, 1) == 0) tex = 0;
      else dest = 0;
    end
    tex_sat = (tex > MAX_SIZE) ? MAX_SIZE : tex;
    kind = $urandom_range(0, 99);
    if (kind < 20 || tex_sat == 0) begin
      near_in = 0;
      far_in  = 0;
    end else if (kind < 75) begin
      // Well-formed insets that leave an interior.
      near_in = $urandom_range(0, tex_sat - 1);
      far_in  = $urandom_range(0, tex_sat - 1 - near_in);
    end else if (kind < 88) begin
      // Insets that cover the whole texture.
      near_in = $urandom_range(0, tex_sat);
      far_in  = tex_sat - near_in + int'($urandom_range(0, 10));
    end else begin
      near_in = $urandom_range(0, tex_sat);
      far_in  = $urandom_range(0, tex_sat);
      if ($urandom_range(0, 1) == 0) near_in = -int'($urandom_range(1, 8192));
      else far_in = -int'($urandom_range(1, 8192));
    end
    if ($urandom_range(0, 1) == 0) crop = int'($urandom_range(0, 64)) - 32;
    else crop = int'(CROP_W'($urandom));
    r = mk_req(tex, near_in, far_in, dest, SIDE_W'($urandom_range(0, 3)), crop);
    r.crop_offset = CROP_W'(crop);
    return r;
  endfunction

  // Presents one item, optionally after an idle burst, and records its expected spans
  // at the edge where it is accepted.
  task automatic send_item(input axis_req_t r, input bit known, input span_t known_span);
    if (!calm_tail && $urandom_range(1, 100) <= in_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.tex_size    <= r.tex_size;
    in_ch.inset_near  <= r.inset_near;
    in_ch.inset_far   <= r.inset_far;
    in_ch.dest_size   <= r.dest_size;
    in_ch.anchor_side <= r.anchor_side;
    in_ch.crop_offset <= r.crop_offset;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (known) spans_due.push_back(known_span);
    else solve_axis(r);
  endtask

  function automatic void check_field(input string name, input logic [LEN_W-1:0] want,
                                      input logic [LEN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result side: every accepted span is matched against the oldest one owed.
  always @(posedge clk) begin
    span_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (spans_due.size() == 0) begin
        $error("span_len: expected no result, actual %0d", out_ch.span_len);
        fail_count++;
      end else begin
        want = spans_due.pop_front();
        check_field("valid_res", LEN_W'(want.valid_res), LEN_W'(out_ch.valid_res));
        check_field("src_start", LEN_W'(want.src_start), LEN_W'(out_ch.src_start));
        check_field("dst_start", LEN_W'(want.dst_start), LEN_W'(out_ch.dst_start));
        check_field("span_len", want.span_len, out_ch.span_len);
        check_field("last_span", LEN_W'(want.last_span), LEN_W'(out_ch.last_span));
        check_field("truncated", LEN_W'(want.truncated), LEN_W'(out_ch.truncated));
      end
    end
  end

  // Receiver backpressure: stalls come in bursts, at a rate the stimulus process
  // changes from phase to phase.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n !== 1'b1 || calm_tail) begin
        stall_left = 0;
        out_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        stall_left = $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed table first, then the random requests, then the drain.
  initial begin
    int n;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.tex_size    = '0;
    in_ch.inset_near  = '0;
    in_ch.inset_far   = '0;
    in_ch.dest_size   = '0;
    in_ch.anchor_side = SIDE_NEAR;
    in_ch.crop_offset = '0;

    // Zero sizes, once with the other fields at their extremes.
    add_known_row(mk_req(0, 0, 0, 100, SIDE_NEAR, 0), mk_span(1'b0, 0, 0, 0));
    add_known_row(mk_req(100, 5, 5, 0, SIDE_FAR, 0), mk_span(1'b0, 0, 0, 0));
    add_known_row(mk_req(0, -8192, 8191, 0, SIDE_SPARE, -4096), mk_span(1'b0, 0, 0, 0));
    // A single interior span, at small and at full size; oversized inputs saturate.
    add_known_row(mk_req(10, 0, 0, 4, SIDE_NEAR, 0), mk_span(1'b1, 0, 0, 4));
    add_known_row(mk_req(4096, 0, 0, 4096, SIDE_NEAR, 0), mk_span(1'b1, 0, 0, 4096));
    add_known_row(mk_req(8191, 0, 0, 8191, SIDE_NEAR, 0), mk_span(1'b1, 0, 0, 4096));
    add_row(mk_req(8191, 100, 200, 8191, SIDE_CENTER, 0));
    // Negative insets and insets that swallow the texture.
    add_row(mk_req(50, -1, 10, 100, SIDE_NEAR, 3));
    add_row(mk_req(50, 10, -8192, 100, SIDE_FAR, 0));
    add_row(mk_req(20, 10, 10, 37, SIDE_NEAR, 0));
    add_row(mk_req(4096, 8191, 0, 300, SIDE_NEAR, 0));
    // Destinations too narrow for the corners.
    add_row(mk_req(100, 40, 40, 10, SIDE_NEAR, 0));
    add_row(mk_req(100, 40, 40, 1, SIDE_NEAR, 0));
    add_row(mk_req(100, 10, 80, 50, SIDE_NEAR, 0));
    // Every anchor code, the unused one included, and the crop extremes.
    add_row(mk_req(7, 1, 2, 30, SIDE_NEAR, 0));
    add_row(mk_req(7, 1, 2, 30, SIDE_CENTER, 0));
    add_row(mk_req(7, 1, 2, 30, SIDE_FAR, 0));
    add_row(mk_req(7, 1, 2, 30, SIDE_SPARE, 0));
    add_row(mk_req(7, 1, 2, 30, SIDE_CENTER, -4096));
    add_row(mk_req(7, 1, 2, 30, SIDE_FAR, 4095));
    // Right at the span limit, one past it and far past it, with and without corners.
    add_row(mk_req(1, 0, 0, 64, SIDE_NEAR, 0));
    add_row(mk_req(1, 0, 0, 65, SIDE_NEAR, 0));
    add_row(mk_req(3, 1, 1, 64, SIDE_NEAR, 0));
    add_row(mk_req(3, 1, 1, 4096, SIDE_CENTER, 5));
    add_row(mk_req(4096, 2048, 2047, 4096, SIDE_FAR, -1));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_pct = 25;
    stall_pct  = 25;
    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].known, dir_rows[i].known_span);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // New idling mix every 50 items, including phases with none at all.
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: begin in_gap_pct = 0;  stall_pct = 0;  end
          1: begin in_gap_pct = 15; stall_pct = 10; end
          2: begin in_gap_pct = 40; stall_pct = 35; end
          default: begin in_gap_pct = 70; stall_pct = 60; end
        endcase
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
      send_item(pick_req(), 1'b0, mk_span(1'b0, 0, 0, 0));
    end
    in_ch.valid <= 1'b0;

    while (spans_due.size() != 0) @(posedge clk);
    // Catch any stray result that trails the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/nssas_pkg.sv
hw/rtl/nssas_if.sv
hw/rtl/nssas_front.sv
hw/rtl/nssas_fifo.sv
hw/rtl/nssas_div.sv
hw/rtl/nssas_back.sv
hw/rtl/nine_slice_axis_span_solver.sv
hw/rtl/nssas_chk.sv
sim/tb.sv
